FILE: src/qsde_pkg.sv
// Shared types, constants and the alphanumeric lookup for the QR segment data encoder.
// Depends on nothing; every other file of the block imports it.
package qsde_pkg;

  localparam int CHAR_W      = 8;
  localparam int BITS_W      = 11;
  localparam int LEN_W       = 4;
  localparam int COUNT_W     = 13;
  localparam int PARTIAL_W   = 10;
  localparam int PEND_W      = 2;
  localparam int MODE_W      = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_NUMERIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALNUM   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BYTE    = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [LEN_W-1:0] LEN_NONE      = 4'd0;
  localparam logic [LEN_W-1:0] LEN_NUM_ONE   = 4'd4;
  localparam logic [LEN_W-1:0] LEN_NUM_TWO   = 4'd7;
  localparam logic [LEN_W-1:0] LEN_NUM_THREE = 4'd10;
  localparam logic [LEN_W-1:0] LEN_ALNUM_ONE = 4'd6;
  localparam logic [LEN_W-1:0] LEN_ALNUM_TWO = 4'd11;
  localparam logic [LEN_W-1:0] LEN_BYTE      = 4'd8;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } qsde_in_t;

  typedef struct packed {
    logic [BITS_W-1:0]  group_bits;
    logic [LEN_W-1:0]   group_len;
    logic               bad_char;
    logic               segment_end;
    logic [COUNT_W-1:0] char_count;
  } qsde_out_t;

  // A classified character as it travels through the queue.
  typedef struct packed {
    logic              ok;
    logic [CHAR_W-1:0] sym;
    logic              last;
  } qsde_item_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } qsde_alnum_t;

  // Index of a character in the 45-symbol QR alphabet.
  function automatic qsde_alnum_t alnum_lookup(input logic [CHAR_W-1:0] c);
    qsde_alnum_t r;
    logic [CHAR_W-1:0] d;
    r.hit = 1'b1;
    r.idx = 6'd0;
    d     = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d     = c - 8'h30;
      r.idx = d[5:0];
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d     = c - 8'h37;
      r.idx = d[5:0];
    end else begin
      case (c)
        8'h20:   r.idx = 6'd36;
        8'h24:   r.idx = 6'd37;
        8'h25:   r.idx = 6'd38;
        8'h2A:   r.idx = 6'd39;
        8'h2B:   r.idx = 6'd40;
        8'h2D:   r.idx = 6'd41;
        8'h2E:   r.idx = 6'd42;
        8'h2F:   r.idx = 6'd43;
        8'h3A:   r.idx = 6'd44;
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: src/qr_segment_data_encoder.sv
// Top level of the QR segment data encoder: mode register, front end, queue and packer.
// Depends on qsde_pkg, qsde_front, qsde_queue and qsde_back.

// Takes one character beat per cycle and gives at most one result beat per character,
// sustaining one character per clock when the result side keeps up. A character is
// classified on the way in and written into a short queue at the edge that accepts it.
// It is packed as it leaves the queue, which happens once the result register is empty or
// being read; its result is then offered from the result register. The queue's storage
// and the result register lie between character and result, and the packing is a
// small multiply-add. While a result waits, the two-entry queue takes up the slack and
// then holds back the input. Writing cfg_wdata with cfg_we selects the mode (0 numeric,
// 1 alphanumeric, 2 or 3 byte) and starts a new segment; write it only while idle.
module qr_segment_data_encoder
  import qsde_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qsde_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qsde_out_t         out_data,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata
);

  logic [MODE_W-1:0] mode_r;
  qsde_item_t        front_item;
  qsde_item_t        back_item;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BYTE;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign in_ready = !q_full;

  qsde_front u_front (
    .mode    (mode_r),
    .in_data (in_data),
    .item    (front_item)
  );

  qsde_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (back_item),
    .empty     (q_empty)
  );

  qsde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .seg_clear  (cfg_we),
    .item_avail (!q_empty),
    .item       (back_item),
    .item_take  (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // A beat that does not close a segment carries no count.
  a_count_only_at_end : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.segment_end) |-> (out_data.char_count == '0))
    else $error("char_count set on a beat that does not end the segment");

  // An unencodable character never carries data bits.
  a_bad_has_no_bits : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_char) |->
      (out_data.group_len == LEN_NONE && out_data.group_bits == '0))
    else $error("bad character beat carries a group");

  // Group lengths are restricted to the sizes the three modes produce.
  a_legal_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.group_len == LEN_NONE || out_data.group_len == LEN_NUM_ONE ||
                   out_data.group_len == LEN_ALNUM_ONE || out_data.group_len == LEN_NUM_TWO ||
                   out_data.group_len == LEN_BYTE || out_data.group_len == LEN_NUM_THREE ||
                   out_data.group_len == LEN_ALNUM_TWO))
    else $error("illegal group length");

  // The result register only fills from an item taken out of the queue.
  a_result_from_item : assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid)) |-> $past(q_pop))
    else $error("result appeared without a queued item");

endmodule

FILE: src/qsde_front.sv
// Front end: accepts character beats and classifies them for the current mode.
// Depends on qsde_pkg.
module qsde_front
  import qsde_pkg::*;
(
  input  logic [MODE_W-1:0] mode,
  input  qsde_in_t          in_data,
  output qsde_item_t        item
);

  qsde_alnum_t       an;
  logic [CHAR_W-1:0] digit;

  always_comb begin
    an        = alnum_lookup(in_data.char_code);
    digit     = in_data.char_code - 8'h30;
    item.last = in_data.last_char;
    unique case (mode)
      MODE_NUMERIC: begin
        item.ok  = (in_data.char_code >= 8'h30) && (in_data.char_code <= 8'h39);
        item.sym = {4'd0, digit[3:0]};
      end
      MODE_ALNUM: begin
        item.ok  = an.hit;
        item.sym = {2'd0, an.idx};
      end
      default: begin
        item.ok  = 1'b1;
        item.sym = in_data.char_code;
      end
    endcase
  end

endmodule

FILE: src/qsde_queue.sv
// Short queue of classified items between the front end and the packer.
// Depends on qsde_pkg.
module qsde_queue
  import qsde_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  qsde_item_t push_item,
  output logic       full,
  input  logic       pop,
  output qsde_item_t pop_item,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qsde_item_t     store_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/qsde_back.sv
// Back end: holds the segment state, packs groups and drives the result register.
// Depends on qsde_pkg.
module qsde_back
  import qsde_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] mode,
  input  logic              seg_clear,
  input  logic              item_avail,
  input  qsde_item_t        item,
  output logic              item_take,
  output logic              out_valid,
  input  logic              out_ready,
  output qsde_out_t         out_data
);

  logic [PARTIAL_W-1:0] partial_r, partial_nxt;
  logic [PEND_W-1:0]    pend_r, pend_nxt;
  logic [COUNT_W-1:0]   seen_r, seen_nxt;
  logic                 skip_r, skip_nxt;
  logic                 out_valid_r, out_valid_nxt;
  qsde_out_t            out_r;

  logic [13:0]          num_val;
  logic [BITS_W-1:0]    an_val;
  logic [BITS_W-1:0]    bits;
  logic [LEN_W-1:0]     len;
  logic                 bad;
  logic                 emit;
  logic [COUNT_W-1:0]   seen_inc;

  assign item_take = item_avail && (!out_valid_r || out_ready);

  always_comb begin
    num_val     = {4'd0, partial_r} * 14'd10 + {10'd0, item.sym[3:0]};
    an_val      = {5'd0, partial_r[5:0]} * 11'd45 + {5'd0, item.sym[5:0]};
    seen_inc    = (seen_r == COUNT_MAX) ? seen_r : seen_r + 1'b1;
    bits        = '0;
    len         = LEN_NONE;
    bad         = 1'b0;
    partial_nxt = partial_r;
    pend_nxt    = pend_r;
    skip_nxt    = skip_r;
    if (!skip_r) begin
      unique case (mode)
        MODE_NUMERIC: begin
          if (!item.ok) begin
            bad = 1'b1;
          end else if (pend_r == 2'd2) begin
            bits        = {1'b0, num_val[PARTIAL_W-1:0]};
            len         = LEN_NUM_THREE;
            partial_nxt = '0;
            pend_nxt    = '0;
          end else begin
            partial_nxt = num_val[PARTIAL_W-1:0];
            pend_nxt    = pend_r + 1'b1;
            if (item.last) begin
              bits = {1'b0, num_val[PARTIAL_W-1:0]};
              len  = (pend_r == 2'd0) ? LEN_NUM_ONE : LEN_NUM_TWO;
            end
          end
        end
        MODE_ALNUM: begin
          if (!item.ok) begin
            bad = 1'b1;
          end else if (pend_r != 2'd0) begin
            bits        = an_val;
            len         = LEN_ALNUM_TWO;
            partial_nxt = '0;
            pend_nxt    = '0;
          end else if (item.last) begin
            bits = {5'd0, item.sym[5:0]};
            len  = LEN_ALNUM_ONE;
          end else begin
            partial_nxt = {4'd0, item.sym[5:0]};
            pend_nxt    = 2'd1;
          end
        end
        default: begin
          bits = {3'd0, item.sym};
          len  = LEN_BYTE;
        end
      endcase
      if (bad) begin
        skip_nxt    = 1'b1;
        partial_nxt = '0;
        pend_nxt    = '0;
      end
    end
    seen_nxt = seen_inc;
    emit     = (len != LEN_NONE) || bad || item.last;
    // Every segment end starts the next segment from clean state.
    if (item.last) begin
      partial_nxt = '0;
      pend_nxt    = '0;
      seen_nxt    = '0;
      skip_nxt    = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      pend_r      <= '0;
      seen_r      <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (seg_clear) begin
        partial_r <= '0;
        pend_r    <= '0;
        seen_r    <= '0;
        skip_r    <= 1'b0;
      end else if (item_take) begin
        partial_r <= partial_nxt;
        pend_r    <= pend_nxt;
        seen_r    <= seen_nxt;
        skip_r    <= skip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      out_r.group_bits  <= bits;
      out_r.group_len   <= len;
      out_r.bad_char    <= bad;
      out_r.segment_end <= item.last;
      out_r.char_count  <= item.last ? seen_inc : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
